[hdl/pps_pkg.sv]
// Shared types, codes and defaults for the per-pixel spectrum histogram.
// No dependencies.
package pps_pkg;

  localparam int NUM_PIXELS_DEF  = 256;
  localparam int NUM_BINS_DEF    = 64;
  localparam int LUT_DEPTH_DEF   = 4096;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int PIX_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int TOFF_W   = 12;
  localparam int BIN_W    = 7;
  localparam int OUT_CNT_W = 32;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ADU_MIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADU_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

  localparam logic [15:0] ADU_MIN_RST     = 16'd0;
  localparam logic [16:0] ADU_MAX_RST     = 17'd4096;
  localparam logic [6:0]  BINS_IN_USE_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_ACCUM     = 2'd0,
    OP_TBL_WRITE = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_COUNTED     = 3'd0,
    STS_OUTSIDE     = 3'd1,
    STS_UNUSED      = 3'd2,
    STS_TBL_WRITTEN = 3'd3,
    STS_READ        = 3'd4,
    STS_CLEARED     = 3'd5,
    STS_BAD_INDEX   = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] adu_min;
    logic [16:0] adu_max;
    logic [6:0]  bins_in_use;
  } cfg_regs_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

endpackage

[hdl/pps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/pps_ctrl.sv]
// Sequencer: decodes items, runs the table lookup and count read-modify-write,
// clears the count memory after reset. Depends on pps_pkg.
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int NUM_PIXELS  = NUM_PIXELS_DEF,
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int LUT_DEPTH   = LUT_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int CNT_DEPTH  = NUM_PIXELS * NUM_BINS,
  localparam int CAW        = $clog2(CNT_DEPTH),
  localparam int LAW        = $clog2(LUT_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_opcode,
  input  logic [PIX_W-1:0]       in_pixel_index,
  input  logic [SAMPLE_W-1:0]    in_sample_value,
  input  logic [TOFF_W-1:0]      in_table_offset,
  input  logic [BIN_W-1:0]       in_bin_index,
  input  cfg_regs_t              cfg,
  output logic                   lut_we,
  output logic [LAW-1:0]         lut_waddr,
  output logic [BIN_W-1:0]       lut_wdata,
  output logic [LAW-1:0]         lut_raddr,
  input  logic [BIN_W-1:0]       lut_rdata,
  output logic                   cnt_we,
  output logic [CAW-1:0]         cnt_waddr,
  output logic [COUNT_WIDTH-1:0] cnt_wdata,
  output logic [CAW-1:0]         cnt_raddr,
  input  logic [COUNT_WIDTH-1:0] cnt_rdata,
  output logic                   res_valid,
  output result_t                res
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LUT   = 4'b0100,
    ST_CNT   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  opcode_t          op_r, op_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [CAW-1:0]   cnt_addr_r, cnt_addr_nxt;
  logic [CAW-1:0]   clr_addr_r, clr_addr_nxt;
  logic             res_valid_r, res_valid_nxt;
  result_t          res_r, res_nxt;

  opcode_t             in_op;
  logic [PIX_W-1:0]    addr_pix;
  logic [BIN_W-1:0]    addr_bin;
  logic [CAW-1:0]      cnt_addr_calc;
  logic [SAMPLE_W-1:0] offset;
  logic                pix_bad, toff_bad, bidx_bad, outside, lut_bin_bad;

  assign in_op    = opcode_t'(in_opcode);
  assign offset   = in_sample_value - cfg.adu_min;
  assign pix_bad  = 32'(in_pixel_index) >= 32'(NUM_PIXELS);
  assign toff_bad = 32'(in_table_offset) >= 32'(LUT_DEPTH);
  assign bidx_bad = 32'(in_bin_index) >= 32'(NUM_BINS);
  assign outside  = (in_sample_value < cfg.adu_min) ||
                    ({1'b0, in_sample_value} >= cfg.adu_max) ||
                    (32'(offset) >= 32'(LUT_DEPTH));
  assign lut_bin_bad = (32'(lut_rdata) >= 32'(cfg.bins_in_use)) ||
                       (32'(lut_rdata) >= 32'(NUM_BINS));

  assign addr_pix      = (state_r == ST_IDLE) ? in_pixel_index : pix_r;
  assign addr_bin      = (state_r == ST_IDLE) ? in_bin_index : lut_rdata;
  assign cnt_addr_calc = CAW'(addr_pix) * CAW'(NUM_BINS) + CAW'(addr_bin);

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pix_nxt       = pix_r;
    cnt_addr_nxt  = cnt_addr_r;
    clr_addr_nxt  = clr_addr_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    lut_we        = 1'b0;
    lut_waddr     = LAW'(in_table_offset);
    lut_wdata     = in_bin_index;
    lut_raddr     = offset[LAW-1:0];
    cnt_we        = 1'b0;
    cnt_waddr     = cnt_addr_r;
    cnt_wdata     = '0;
    cnt_raddr     = cnt_addr_calc;

    unique case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_r;
        if (clr_addr_r == CAW'(CNT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt        = in_op;
          pix_nxt       = in_pixel_index;
          cnt_addr_nxt  = cnt_addr_calc;
          res_valid_nxt = 1'b1;
          res_nxt.count = '0;
          unique case (in_op)
            OP_TBL_WRITE: begin
              if (toff_bad) begin
                res_nxt.status = STS_BAD_INDEX;
              end else begin
                lut_we         = 1'b1;
                res_nxt.status = STS_TBL_WRITTEN;
              end
            end
            OP_ACCUM: begin
              if (pix_bad) begin
                res_nxt.status = STS_BAD_INDEX;
              end else if (outside) begin
                res_nxt.status = STS_OUTSIDE;
              end else begin
                res_valid_nxt = 1'b0;
                state_nxt     = ST_LUT;
              end
            end
            OP_READ: begin
              if (pix_bad || bidx_bad) begin
                res_nxt.status = STS_BAD_INDEX;
              end else begin
                res_valid_nxt = 1'b0;
                state_nxt     = ST_CNT;
              end
            end
            OP_CLEAR: begin
              if (pix_bad || bidx_bad) begin
                res_nxt.status = STS_BAD_INDEX;
              end else begin
                cnt_we         = 1'b1;
                cnt_waddr      = cnt_addr_calc;
                res_nxt.status = STS_CLEARED;
              end
            end
            default: res_nxt.status = STS_BAD_INDEX;
          endcase
        end
      end
      ST_LUT: begin
        cnt_addr_nxt = cnt_addr_calc;
        if (lut_bin_bad) begin
          res_valid_nxt  = 1'b1;
          res_nxt.status = STS_UNUSED;
          res_nxt.count  = '0;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        state_nxt     = ST_IDLE;
        res_valid_nxt = 1'b1;
        if (op_r == OP_READ) begin
          res_nxt.status = STS_READ;
          res_nxt.count  = OUT_CNT_W'(cnt_rdata);
        end else begin
          cnt_we         = 1'b1;
          cnt_wdata      = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
          res_nxt.status = STS_COUNTED;
          res_nxt.count  = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      res_valid_r <= 1'b0;
      op_r        <= OP_ACCUM;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      res_valid_r <= res_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    cnt_addr_r <= cnt_addr_nxt;
    res_r      <= res_nxt;
  end

endmodule

[hdl/per_pixel_spectrum_histogram.sv]
// Top level of the per-pixel spectrum histogram: config registers, bin table
// and count memories, sequencer. Depends on pps_pkg, pps_ram, pps_ctrl.
//
// After reset the block sweeps the count memory to zero, one entry per cycle,
// NUM_PIXELS*NUM_BINS entries (16384 by default) with busy high; config writes
// are taken meanwhile. An item is taken when start is high and busy is low.
// Table writes, clears and items rejected by the index or window checks keep
// busy low: the next item may follow at once. A count read holds busy high in
// ST_CNT. An accumulate that passes the window does a table read and, if the
// looked-up bin is counted, a count read and write-back; an unused bin ends
// after the table read. Each beat shows on out_status/out_count for one cycle
// with out_valid high; it cannot be held.
module per_pixel_spectrum_histogram
  import pps_pkg::*;
#(
  parameter int NUM_PIXELS  = NUM_PIXELS_DEF,
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int LUT_DEPTH   = LUT_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [PIX_W-1:0]      in_pixel_index,
  input  logic [SAMPLE_W-1:0]   in_sample_value,
  input  logic [TOFF_W-1:0]     in_table_offset,
  input  logic [BIN_W-1:0]      in_bin_index,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [OUT_CNT_W-1:0]  out_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_DEPTH = NUM_PIXELS * NUM_BINS;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int LAW       = $clog2(LUT_DEPTH);

  cfg_regs_t cfg_r, cfg_nxt;

  logic                   lut_we;
  logic [LAW-1:0]         lut_waddr, lut_raddr;
  logic [BIN_W-1:0]       lut_wdata, lut_rdata;
  logic                   cnt_we;
  logic [CAW-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  result_t                res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADU_MIN:     cfg_nxt.adu_min     = cfg_data[15:0];
        CFG_ADU_MAX:     cfg_nxt.adu_max     = cfg_data[16:0];
        CFG_BINS_IN_USE: cfg_nxt.bins_in_use = cfg_data[6:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adu_min     <= ADU_MIN_RST;
      cfg_r.adu_max     <= ADU_MAX_RST;
      cfg_r.bins_in_use <= BINS_IN_USE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pps_ram #(
    .WIDTH (BIN_W),
    .DEPTH (LUT_DEPTH)
  ) u_lut_ram (
    .clk   (clk),
    .we    (lut_we),
    .waddr (lut_waddr),
    .wdata (lut_wdata),
    .raddr (lut_raddr),
    .rdata (lut_rdata)
  );

  pps_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pps_ctrl #(
    .NUM_PIXELS  (NUM_PIXELS),
    .NUM_BINS    (NUM_BINS),
    .LUT_DEPTH   (LUT_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_pixel_index  (in_pixel_index),
    .in_sample_value (in_sample_value),
    .in_table_offset (in_table_offset),
    .in_bin_index    (in_bin_index),
    .cfg             (cfg_r),
    .lut_we          (lut_we),
    .lut_waddr       (lut_waddr),
    .lut_wdata       (lut_wdata),
    .lut_raddr       (lut_raddr),
    .lut_rdata       (lut_rdata),
    .cnt_we          (cnt_we),
    .cnt_waddr       (cnt_waddr),
    .cnt_wdata       (cnt_wdata),
    .cnt_raddr       (cnt_raddr),
    .cnt_rdata       (cnt_rdata),
    .res_valid       (out_valid),
    .res             (res)
  );

  assign out_status = res.status;
  assign out_count  = res.count;

endmodule

[verif/tb_per_pixel_spectrum_histogram.sv]
`timescale 1ns / 100ps
// Self-checking testbench for per_pixel_spectrum_histogram: directed table, then random
// phases over several window settings; beats are checked against typed table rows or
// an in-bench predictor. Depends on pps_pkg and per_pixel_spectrum_histogram's RTL.
module tb_per_pixel_spectrum_histogram;
  import pps_pkg::*;

  localparam int NUM_PIXELS  = NUM_PIXELS_DEF;
  localparam int NUM_BINS    = NUM_BINS_DEF;
  localparam int LUT_DEPTH   = LUT_DEPTH_DEF;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 195;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_LO = 14;
  localparam int IDLE_HI = 51;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  pix;
    logic [15:0] smp;
    logic [11:0] toff;
    logic [6:0]  bidx;
    bit          typed;
    status_t     st;
    logic [31:0] cnt;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_d;
    logic [CFG_DATA_W-1:0] max_d;
    logic [CFG_DATA_W-1:0] bins_d;
    bit                    spare;
    int                    idle_pct;
  } window_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_opcode;
  logic [PIX_W-1:0]      in_pixel_index;
  logic [SAMPLE_W-1:0]   in_sample_value;
  logic [TOFF_W-1:0]     in_table_offset;
  logic [BIN_W-1:0]      in_bin_index;
  logic                  out_valid;
  logic [2:0]            out_status;
  logic [OUT_CNT_W-1:0]  out_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit [31:0]   spectrum [NUM_PIXELS*NUM_BINS];
  bit [6:0]    bin_table [LUT_DEPTH];
  bit          table_written [LUT_DEPTH];
  logic [11:0] written_offsets [$];
  logic [15:0] model_adu_min = ADU_MIN_RST;
  logic [16:0] model_adu_max = ADU_MAX_RST;
  logic [6:0]  model_bins    = BINS_IN_USE_RST;

  result_t pending_results [$];
  result_t due;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,      8'd0,   16'd0,     12'd0,    7'd0,   1'b1, STS_READ,        32'd0},
    '{OP_READ,      8'd255, 16'd0,     12'd0,    7'd63,  1'b1, STS_READ,        32'd0},
    '{OP_READ,      8'd3,   16'd0,     12'd0,    7'd64,  1'b1, STS_BAD_INDEX,   32'd0},
    '{OP_CLEAR,     8'd9,   16'd0,     12'd0,    7'd127, 1'b1, STS_BAD_INDEX,   32'd0},
    '{OP_TBL_WRITE, 8'd0,   16'd0,     12'd0,    7'd5,   1'b1, STS_TBL_WRITTEN, 32'd0},
    '{OP_TBL_WRITE, 8'd0,   16'd0,     12'd4095, 7'd127, 1'b1, STS_TBL_WRITTEN, 32'd0},
    '{OP_TBL_WRITE, 8'd0,   16'd0,     12'd1,    7'd63,  1'b1, STS_TBL_WRITTEN, 32'd0},
    '{OP_TBL_WRITE, 8'd0,   16'd0,     12'd2,    7'd64,  1'b1, STS_TBL_WRITTEN, 32'd0},
    '{OP_ACCUM,     8'd0,   16'd0,     12'd0,    7'd0,   1'b1, STS_COUNTED,     32'd0},
    '{OP_ACCUM,     8'd0,   16'd0,     12'd0,    7'd0,   1'b0, STS_COUNTED,     32'd0},
    '{OP_ACCUM,     8'd0,   16'd0,     12'd0,    7'd0,   1'b0, STS_COUNTED,     32'd0},
    '{OP_READ,      8'd0,   16'd0,     12'd0,    7'd5,   1'b0, STS_COUNTED,     32'd0},
    '{OP_ACCUM,     8'd255, 16'd1,     12'd0,    7'd0,   1'b1, STS_COUNTED,     32'd0},
    '{OP_ACCUM,     8'd255, 16'd2,     12'd0,    7'd0,   1'b1, STS_UNUSED,      32'd0},
    '{OP_ACCUM,     8'd7,   16'd4095,  12'd0,    7'd0,   1'b1, STS_UNUSED,      32'd0},
    '{OP_ACCUM,     8'd7,   16'd4096,  12'd0,    7'd0,   1'b1, STS_OUTSIDE,     32'd0},
    '{OP_ACCUM,     8'd7,   16'd65535, 12'd0,    7'd0,   1'b1, STS_OUTSIDE,     32'd0},
    '{OP_READ,      8'd255, 16'd0,     12'd0,    7'd63,  1'b0, STS_COUNTED,     32'd0},
    '{OP_CLEAR,     8'd0,   16'd0,     12'd0,    7'd5,   1'b1, STS_CLEARED,     32'd0},
    '{OP_READ,      8'd0,   16'd0,     12'd0,    7'd5,   1'b1, STS_READ,        32'd0},
    '{OP_ACCUM,     8'd0,   16'd0,     12'd0,    7'd0,   1'b0, STS_COUNTED,     32'd0},
    '{OP_READ,      8'd0,   16'd0,     12'd0,    7'd5,   1'b0, STS_COUNTED,     32'd0},
    '{OP_CLEAR,     8'd255, 16'd0,     12'd0,    7'd63,  1'b0, STS_COUNTED,     32'd0},
    '{OP_ACCUM,     8'd255, 16'd1,     12'd0,    7'd0,   1'b0, STS_COUNTED,     32'd0},
    '{OP_READ,      8'd255, 16'd0,     12'd0,    7'd63,  1'b0, STS_COUNTED,     32'd0}
  };

  window_setting_t settings [NUM_PHASES] = '{
    '{17'd0,      17'd4096,  17'd64,    1'b0, IDLE_LO},
    '{17'd0,      17'd65536, 17'd127,   1'b0, IDLE_LO},
    '{17'd200,    17'd1200,  17'd16,    1'b0, IDLE_LO},
    '{17'd65535,  17'd65536, 17'd64,    1'b0, IDLE_HI},
    '{17'd1000,   17'd500,   17'd1,     1'b0, IDLE_HI},
    '{17'd3000,   17'd0,     17'd0,     1'b1, IDLE_HI},
    '{17'd10,     17'd2058,  17'd40,    1'b0, 0},
    '{17'h10064,  17'd4196,  17'h00F40, 1'b0, 0}
  };

  per_pixel_spectrum_histogram i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_pixel_index  (in_pixel_index),
    .in_sample_value (in_sample_value),
    .in_table_offset (in_table_offset),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic result_t predict_spectrum(opcode_t op, logic [7:0] pix,
                                               logic [15:0] smp, logic [11:0] toff,
                                               logic [6:0] bidx);
    result_t     r;
    logic [15:0] off;
    logic [6:0]  bin;
    int          slot;
    r.count = '0;
    off = smp - model_adu_min;
    if (op == OP_TBL_WRITE) begin
      if (int'(toff) >= LUT_DEPTH) begin
        r.status = STS_BAD_INDEX;
      end else begin
        bin_table[toff] = bidx;
        if (!table_written[toff]) begin
          table_written[toff] = 1'b1;
          written_offsets.push_back(toff);
        end
        r.status = STS_TBL_WRITTEN;
      end
    end else if (int'(pix) >= NUM_PIXELS) begin
      r.status = STS_BAD_INDEX;
    end else if (op == OP_ACCUM) begin
      if (smp < model_adu_min || {1'b0, smp} >= model_adu_max || int'(off) >= LUT_DEPTH) begin
        r.status = STS_OUTSIDE;
      end else begin
        bin = bin_table[off[11:0]];
        if (bin >= model_bins || int'(bin) >= NUM_BINS) begin
          r.status = STS_UNUSED;
        end else begin
          slot = int'(pix) * NUM_BINS + int'(bin);
          if (spectrum[slot] != '1) spectrum[slot] = spectrum[slot] + 1;
          r.status = STS_COUNTED;
        end
      end
    end else if (int'(bidx) >= NUM_BINS) begin
      r.status = STS_BAD_INDEX;
    end else begin
      slot = int'(pix) * NUM_BINS + int'(bidx);
      if (op == OP_READ) begin
        r.status = STS_READ;
        r.count  = spectrum[slot];
      end else begin
        spectrum[slot] = '0;
        r.status = STS_CLEARED;
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] pick_bin();
    int r;
    r = $urandom_range(9);
    if (r < 7) return 7'($urandom_range(15));
    if (r < 9) return 7'($urandom_range(63));
    return 7'($urandom_range(127));
  endfunction

  // start stays high across back-to-back beats; it only drops for a gap
  task automatic send_beat(input opcode_t op, input logic [7:0] pix, input logic [15:0] smp,
                           input logic [11:0] toff, input logic [6:0] bidx,
                           input bit typed, input result_t typed_res, input int idle_pct);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_pixel_index  <= pix;
    in_sample_value <= smp;
    in_table_offset <= toff;
    in_bin_index    <= bidx;
    do @(posedge clk); while (busy !== 1'b0);
    r = predict_spectrum(op, pix, smp, toff, bidx);
    if (typed) r = typed_res;
    pending_results.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_ADU_MIN:     model_adu_min = data[15:0];
      CFG_ADU_MAX:     model_adu_max = data[16:0];
      CFG_BINS_IN_USE: model_bins    = data[6:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, status %0d count %0d", $time, out_status, out_count);
        mismatch_count++;
      end else begin
        due = pending_results.pop_front();
        if (out_status !== due.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, due.status, out_status);
          mismatch_count++;
        end
        if (out_count !== due.count) begin
          $display("%0t: count expected %0d, actual %0d", $time, due.count, out_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    opcode_t     op;
    logic [7:0]  pix;
    logic [15:0] smp;
    logic [11:0] toff;
    logic [6:0]  bidx;
    int          sel;
    int          lim;
    int          off;
    int          tries;
    bit          hit;
    result_t     typed_res;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_ACCUM;
    in_pixel_index  <= '0;
    in_sample_value <= '0;
    in_table_offset <= '0;
    in_bin_index    <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ADU_MIN;
    cfg_data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].st;
      typed_res.count  = directed_rows[i].cnt;
      send_beat(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].smp,
                directed_rows[i].toff, directed_rows[i].bidx, directed_rows[i].typed,
                typed_res, IDLE_LO);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ADU_MIN, settings[p].min_d);
      write_reg(CFG_ADU_MAX, settings[p].max_d);
      write_reg(CFG_BINS_IN_USE, settings[p].bins_d);
      if (settings[p].spare) write_reg(CFG_UNMAPPED, 17'($urandom));
      cfg_we <= 1'b0;
      lim = int'(model_adu_max) - int'(model_adu_min);
      if (lim > LUT_DEPTH) lim = LUT_DEPTH;
      if (lim < 0) lim = 0;

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        pix  = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        smp  = 16'($urandom_range(65535));
        toff = 12'($urandom_range(4095));
        bidx = 7'($urandom_range(127));
        sel  = $urandom_range(99);
        if (sel < 55) op = OP_ACCUM;
        else if (sel < 70) op = OP_TBL_WRITE;
        else if (sel < 92) op = OP_READ;
        else op = OP_CLEAR;

        if (op == OP_TBL_WRITE) begin
          if ($urandom_range(9) != 0) toff = 12'($urandom_range(63));
          bidx = pick_bin();
        end else if (op != OP_ACCUM) begin
          bidx = pick_bin();
        end else begin
          if (lim > 0 && $urandom_range(99) < 80) begin
            off = $urandom_range(lim - 1);
            hit = table_written[off];
            for (tries = 0; tries < 8 && !hit; tries++) begin
              off = int'(written_offsets[$urandom_range(written_offsets.size() - 1)]);
              hit = off < lim;
            end
            if (hit) smp = 16'(int'(model_adu_min) + off);
          end
          // never look up a table entry that was not loaded
          off = int'(smp) - int'(model_adu_min);
          if (off >= 0 && off < LUT_DEPTH && {1'b0, smp} < model_adu_max &&
              !table_written[off]) begin
            if (model_adu_min != 0)
              smp = 16'($urandom_range(int'(model_adu_min) - 1));
            else if (model_adu_max <= 17'd65535)
              smp = 16'($urandom_range(65535, int'(model_adu_max)));
            else
              smp = 16'($urandom_range(65535, LUT_DEPTH));
          end
        end
        send_beat(op, pix, smp, toff, bidx, 1'b0, typed_res, settings[p].idle_pct);
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/pps_ctrl.sv
hdl/per_pixel_spectrum_histogram.sv
verif/tb_per_pixel_spectrum_histogram.sv
